// File: design/ioh_pkg.sv
// shared constants and the cordic table function for the integral orientation histogram
package ioh_pkg;

  localparam int MaxBins    = 16;
  localparam int MaxWidth   = 1024;
  localparam int MaxHeight  = 1024;
  localparam int BinW       = $clog2(MaxBins);
  localparam int ColW       = $clog2(MaxWidth);
  localparam int RowW       = $clog2(MaxHeight);
  localparam int StoreDepth = MaxWidth * MaxBins;
  localparam int StoreAw    = $clog2(StoreDepth);
  localparam int ValW       = 48;
  localparam int SumW       = 32;
  localparam int GradW      = 11;

  // register indexes
  localparam logic [1:0] RegNumBins  = 2'd0;
  localparam logic [1:0] RegFullOri  = 2'd1;
  localparam logic [1:0] RegWidth    = 2'd2;
  localparam logic [1:0] RegHeight   = 2'd3;
  localparam int         CfgW        = 11;

  // angles in 1/256 degree
  localparam logic [16:0] Deg90  = 17'd23040;
  localparam logic [16:0] Deg180 = 17'd46080;
  localparam logic [16:0] Deg360 = 17'd92160;

  // cordic arctangent table, degrees scaled by 65536
  function automatic logic [21:0] atan_lut(input logic [3:0] i);
    logic [21:0] r;
    unique case (i)
      4'd0:  r = 22'd2949120;
      4'd1:  r = 22'd1740967;
      4'd2:  r = 22'd919879;
      4'd3:  r = 22'd466945;
      4'd4:  r = 22'd234379;
      4'd5:  r = 22'd117304;
      4'd6:  r = 22'd58666;
      4'd7:  r = 22'd29335;
      4'd8:  r = 22'd14668;
      4'd9:  r = 22'd7334;
      4'd10: r = 22'd3667;
      4'd11: r = 22'd1833;
      4'd12: r = 22'd917;
      4'd13: r = 22'd458;
      4'd14: r = 22'd229;
      default: r = 22'd115;
    endcase
    return r;
  endfunction

endpackage

// File: design/integral_orientation_histogram.sv
// top level of the integral orientation histogram
// Usage:
//  input channel: one gradient pair (grad_x_i, grad_y_i) per pixel in raster
//  order, valid/stall handshake; the block stalls while a pixel is in work.
//  output channel: one transaction per bin in use, bin 0 first, last_bin_o
//  marks the highest bin; integral values carry 8 fractional bits and clamp
//  at 2^48-1 with saturated_o set.
//  config port: cfg_we_i, cfg_index_i, cfg_data_i; write only while idle.
//  Sequence: the shared magnitude/angle unit runs 20 square root steps, cordic
//  on the first 16, then a quadrant fix; the bin position follows (reciprocal
//  multiply), then the bin split and two bin updates; then each bin passes
//  through the single port row store (read, then write back and present).
//  Reset: counters clear, registers take defaults (8 bins, folded, 640x480);
//  the row store is left unset, row 0 never reads it.
//  A stalled output holds its data and the sequencer waits on it.
module integral_orientation_histogram
  import ioh_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [GradW-1:0]  grad_x_i,
  input  logic signed [GradW-1:0]  grad_y_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [BinW-1:0]          bin_index_o,
  output logic [ValW-1:0]          integral_value_o,
  output logic                     last_bin_o,
  output logic                     saturated_o,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_index_i,
  input  logic [CfgW-1:0]          cfg_data_i
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StFeat = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StUpd  = 3'd3;
  localparam logic [2:0] StRd   = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  // ceil(2^24 / 45), exact for quotients of operands below 2^18
  localparam logic [18:0] Recip45 = 19'd372828;

  logic [2:0]  state_q, state_d;
  logic [4:0]  nb_cfg_q;
  logic        full_q;
  logic [10:0] w_cfg_q, h_cfg_q;
  logic [ColW-1:0] col_q, col_d;
  logic [RowW-1:0] row_q, row_d, row_base;
  logic [SumW-1:0] sums_q [MaxBins];
  logic [SumW-1:0] sum_nv;
  logic        clr_sums;
  logic [4:0]  nb;
  logic [10:0] w, h;
  logic        accept;

  logic        f_done;
  logic [19:0] mag;
  logic [16:0] ang_raw;
  logic [19:0] mag_q;

  // bin position pos = ang*nb / 180 or / 360, by shift and reciprocal multiply
  logic [31:0] dnum_q, dnum_d;
  logic [17:0] dscaled;
  logic [37:0] pmul;
  logic [13:0] dquo;
  logic [16:0] range, ang_f;
  logic [BinW-1:0] bin0_q, bin1_q, bidx_q, bidx_d;
  logic [7:0]  frac;
  logic [27:0] p1full;
  logic [19:0] part1_q, part0_q;
  logic [1:0]  upd_q;
  logic [SumW:0] addv;

  logic [StoreAw-1:0] st_addr;
  logic        st_we;
  logic [ValW-1:0] st_rdata, wval;
  logic [ValW:0] vsum;
  logic        ovalid_q;
  logic [ValW-1:0] oval_q;
  logic        osat_q, olast_q;
  logic [BinW-1:0] obin_q;

  assign nb = (nb_cfg_q == 5'd0) ? 5'd1 : (nb_cfg_q > 5'(MaxBins) ? 5'(MaxBins) : nb_cfg_q);
  assign w  = (w_cfg_q == 11'd0) ? 11'd1 : (w_cfg_q > 11'(MaxWidth) ? 11'(MaxWidth) : w_cfg_q);
  assign h  = (h_cfg_q == 11'd0) ? 11'd1 : (h_cfg_q > 11'(MaxHeight) ? 11'(MaxHeight) : h_cfg_q);
  assign in_stall_o = (state_q != StIdle);
  assign accept = in_valid_i && !in_stall_o;
  assign row_base = (11'(row_q) >= h) ? '0 : row_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nb_cfg_q <= 5'd8; full_q <= 1'b0; w_cfg_q <= 11'd640; h_cfg_q <= 11'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegNumBins: nb_cfg_q <= cfg_data_i[4:0];
        RegFullOri: full_q   <= cfg_data_i[0];
        RegWidth:   w_cfg_q  <= cfg_data_i;
        default:    h_cfg_q  <= cfg_data_i;
      endcase
    end
  end

  ioh_feature u_feature (
    .clk_i, .rst_ni, .start_i(accept), .grad_x_i, .grad_y_i,
    .done_o(f_done), .mag_o(mag), .ang_o(ang_raw)
  );

  assign range = full_q ? Deg360 : Deg180;
  assign ang_f = (ang_raw >= range) ? ang_raw - range : ang_raw;
  // 180 = 4*45 and 360 = 8*45
  assign dscaled = full_q ? 18'(dnum_q >> 3) : 18'(dnum_q >> 2);
  assign pmul  = 38'(dscaled) * 38'(Recip45);
  assign dquo  = pmul[37:24];
  assign frac  = dnum_q[7:0];
  assign p1full = 28'(mag_q) * 28'(frac);

  // row sum update value for the bin under update
  always_comb begin
    addv = (SumW+1)'(sums_q[bidx_q]) + (SumW+1)'((upd_q == 2'd2) ? part1_q : part0_q);
    sum_nv = addv[SumW] ? '1 : addv[SumW-1:0];
  end

  // previous row plus row sum, clamped
  assign vsum = (ValW+1)'(row_q == '0 ? '0 : st_rdata) + (ValW+1)'(sums_q[bidx_q]);
  assign wval = vsum[ValW] ? '1 : vsum[ValW-1:0];
  assign st_addr = {col_q, bidx_q};
  assign st_we = (state_q == StOut) && !ovalid_q;

  ioh_ram #(.Width(ValW), .Depth(StoreDepth)) u_store (
    .clk_i, .we_i(st_we), .addr_i(st_addr), .wdata_i(wval), .rdata_o(st_rdata)
  );

  // main sequencer
  always_comb begin
    state_d = state_q; col_d = col_q; row_d = row_q; bidx_d = bidx_q;
    dnum_d = dnum_q; clr_sums = 1'b0;
    unique case (state_q)
      StIdle: if (accept) begin
        state_d = StFeat;
        row_d = row_base;
        if (11'(col_q) >= w) begin
          col_d = '0; clr_sums = 1'b1;
          row_d = (11'(row_base) + 11'd1 >= h) ? '0 : row_base + 1'b1;
        end
      end
      StFeat: if (f_done) begin
        state_d = StDiv; dnum_d = 32'(ang_f) * 32'(nb);
      end
      StDiv: begin
        dnum_d = 32'(dquo); state_d = StUpd; bidx_d = '0;
      end
      // split, then bin0 takes part0, then bin1 takes part1
      StUpd: begin
        unique case (upd_q)
          2'd0: bidx_d = bin0_q;
          2'd1: bidx_d = bin1_q;
          default: begin state_d = StRd; bidx_d = '0; end
        endcase
      end
      StRd: state_d = StOut;
      StOut: if (!ovalid_q) begin
        if (5'(bidx_q) + 5'd1 >= nb) begin
          state_d = StIdle;
          if (11'(col_q) + 11'd1 >= w) begin
            col_d = '0; clr_sums = 1'b1;
            row_d = (11'(row_q) + 11'd1 >= h) ? '0 : row_q + 1'b1;
          end else col_d = col_q + 1'b1;
        end else begin
          bidx_d = bidx_q + 1'b1; state_d = StRd;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; col_q <= '0; row_q <= '0; upd_q <= '0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < MaxBins; i++) sums_q[i] <= '0;
    end else begin
      state_q <= state_d; col_q <= col_d; row_q <= row_d;
      if (clr_sums) begin
        for (int i = 0; i < MaxBins; i++) sums_q[i] <= '0;
      end else if (state_q == StUpd && upd_q != 2'd0) begin
        sums_q[bidx_q] <= sum_nv;
      end
      upd_q <= (state_q == StUpd && upd_q != 2'd2) ? upd_q + 2'd1 : 2'd0;
      if (ovalid_q && !out_stall_i) ovalid_q <= 1'b0;
      else if (st_we) ovalid_q <= 1'b1;
    end
  end

  // datapath registers; row sums of the two bins are done one per cycle
  always_ff @(posedge clk_i) begin
    dnum_q <= dnum_d;
    bidx_q <= bidx_d;
    if (f_done) mag_q <= mag;
    if (state_q == StDiv) begin
      // bin split from the quotient
      bin0_q <= (5'(dquo[11:8]) >= nb || dquo[13:12] != '0) ? BinW'(nb - 5'd1)
              : dquo[11:8];
    end
    if (state_q == StUpd && upd_q == 2'd0) begin
      part1_q <= 20'(p1full >> 8);
      part0_q <= mag_q - 20'(p1full >> 8);
      bin1_q <= (5'(bin0_q) + 5'd1 >= nb) ? '0 : bin0_q + 1'b1;
    end
    if (st_we) begin
      oval_q <= wval; osat_q <= vsum[ValW]; obin_q <= bidx_q;
      olast_q <= (5'(bidx_q) + 5'd1 >= nb);
    end
  end

  assign out_valid_o      = ovalid_q;
  assign bin_index_o      = obin_q;
  assign integral_value_o = oval_q;
  assign last_bin_o       = olast_q;
  assign saturated_o      = osat_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o) else $error("accepted while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && out_stall_i) |=> (ovalid_q && $stable(oval_q))) else $error("output lost");
  a_bin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we |-> (5'(bidx_q) < nb)) else $error("bin beyond count");
endmodule

// File: design/ioh_ram.sv
// generic single port ram with registered read
module ioh_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // write, and registered read of the old contents
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: design/ioh_feature.sv
// magnitude and angle unit: bit serial square root and cordic share one sequencer
module ioh_feature (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [ioh_pkg::GradW-1:0] grad_x_i,
  input  logic signed [ioh_pkg::GradW-1:0] grad_y_i,
  output logic                         done_o,
  output logic [19:0]                  mag_o,
  output logic [16:0]                  ang_o
);
  import ioh_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  logic [1:0]  state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [39:0] rad_q, rad_d;      // sqrt radicand
  logic [39:0] rem_q, rem_d;
  logic [19:0] root_q, root_d;
  logic signed [29:0] x_q, x_d, y_q, y_d;
  logic signed [23:0] z_q, z_d;
  logic        xneg_q, yneg_q, ysel_q, xsel_q;
  logic [16:0] ang_q, ang_d;
  logic        done_q, done_d;

  logic [10:0] ax, ay;
  logic [21:0] sq;
  logic [39:0] trial;
  logic [41:0] remsh;
  logic signed [29:0] xs, ys;
  logic signed [23:0] zc;
  logic [16:0] q, a;

  assign ax = grad_x_i[GradW-1] ? 11'(-grad_x_i) : grad_x_i;
  assign ay = grad_y_i[GradW-1] ? 11'(-grad_y_i) : grad_y_i;
  assign sq = 22'(ax * ax) + 22'(ay * ay);
  assign remsh = {rem_q, rad_q[39:38]};
  assign trial = 40'({root_q, 2'b01});
  assign xs = x_q >>> cnt_q[3:0];
  assign ys = y_q >>> cnt_q[3:0];

  // clamp and round the cordic angle, then place it in its quadrant
  always_comb begin
    zc = z_q;
    if (z_q < 0) zc = '0;
    if (z_q > 24'sd5898240) zc = 24'sd5898240;
    q = ysel_q ? 17'd0 : (xsel_q ? Deg90 : 17'((zc + 24'sd128) >>> 8));
    if (!xneg_q && !yneg_q) a = q;
    else if (xneg_q && !yneg_q) a = Deg180 - q;
    else if (xneg_q) a = Deg180 + q;
    else a = Deg360 - q;
    if (a >= Deg360) a = a - Deg360;
  end

  // sequencer: 20 root steps, cordic runs on the first 16
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; rad_d = rad_q; rem_d = rem_q;
    root_d = root_q; x_d = x_q; y_d = y_q; z_d = z_q; ang_d = ang_q;
    done_d = 1'b0;
    unique case (state_q)
      StIdle: if (start_i) begin
        state_d = StRun; cnt_d = '0;
        rad_d = {2'b00, sq, 16'd0}; rem_d = '0; root_d = '0;
        x_d = 30'(ax) <<< 16; y_d = 30'(ay) <<< 16; z_d = '0;
      end
      StRun: begin
        if (42'(trial) <= remsh) begin
          rem_d = 40'(remsh - 42'(trial)); root_d = {root_q[18:0], 1'b1};
        end else begin
          rem_d = 40'(remsh); root_d = {root_q[18:0], 1'b0};
        end
        rad_d = rad_q << 2;
        if (cnt_q < 5'd16) begin
          if (y_q >= 0) begin
            x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + 24'(atan_lut(cnt_q[3:0]));
          end else begin
            x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - 24'(atan_lut(cnt_q[3:0]));
          end
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd19) state_d = StFin;
      end
      StFin: begin
        ang_d = a; done_d = 1'b1; state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      state_q <= state_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q <= rad_d; rem_q <= rem_d; root_q <= root_d;
    x_q <= x_d; y_q <= y_d; z_q <= z_d; ang_q <= ang_d;
    if (state_q == StIdle && start_i) begin
      xneg_q <= grad_x_i[GradW-1]; yneg_q <= grad_y_i[GradW-1];
      ysel_q <= (ay == 11'd0); xsel_q <= (ax == 11'd0);
    end
  end

  assign done_o = done_q;
  assign mag_o  = root_q;
  assign ang_o  = ang_q;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("done held");
  a_ang_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ang_q < Deg360) else $error("angle out of range");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == StRun) |-> $past(start_i)) else $error("run without start");
endmodule

// File: tb/sv/integral_orientation_histogram_checker.sv
// checker for the integral orientation histogram: predicts bin results and compares them
`timescale 1ns / 1ps
module integral_orientation_histogram_checker
  import ioh_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic signed [GradW-1:0] grad_x_i,
  input  logic signed [GradW-1:0] grad_y_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [BinW-1:0]         bin_index_i,
  input  logic [ValW-1:0]         integral_value_i,
  input  logic                    last_bin_i,
  input  logic                    saturated_i,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_index_i,
  input  logic [CfgW-1:0]         cfg_data_i,
  output int                      pending_o,
  output int                      fail_count_o,
  output int                      result_count_o
);

  typedef struct packed {
    logic [BinW-1:0] bin;
    logic [ValW-1:0] value;
    logic            last;
    logic            sat;
  } bin_result_t;

  localparam longint unsigned ValMax = 64'hFFFF_FFFF_FFFF;
  localparam longint unsigned SumMax = 64'hFFFF_FFFF;
  localparam longint AtanDeg [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                      58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                      229, 115};

  bin_result_t     expected_bins[$];
  logic [SumW-1:0] row_sum[MaxBins];
  logic [ValW-1:0] prev_row[StoreDepth];
  int unsigned     col_cnt;
  int unsigned     row_cnt;
  logic [4:0]      bins_reg;
  logic            full_reg;
  logic [10:0]     width_reg;
  logic [10:0]     height_reg;

  assign pending_o = expected_bins.size();

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // first-quadrant angle in 1/256 degree by cordic vectoring
  function automatic int unsigned first_quadrant_angle(input int unsigned ax, input int unsigned ay);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    if (ay == 0) return 0;
    if (ax == 0) return 90 * 256;
    x = longint'(ax) * 65536;
    y = longint'(ay) * 65536;
    z = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += AtanDeg[i];
      end else begin
        x -= ys; y += xs; z -= AtanDeg[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 90 * 65536) z = 90 * 65536;
    return int'((z + 128) >>> 8);
  endfunction

  function automatic int unsigned clamp_range(input int unsigned v, input int unsigned lo,
                                              input int unsigned hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic advance_row(input int unsigned h);
    col_cnt = 0;
    row_cnt++;
    if (row_cnt >= h) row_cnt = 0;
    for (int n = 0; n < MaxBins; n++) row_sum[n] = '0;
  endtask

  // bin results of one pixel
  task automatic predict_pixel(input logic signed [GradW-1:0] gx, input logic signed [GradW-1:0] gy);
    int unsigned     nb;
    int unsigned     w;
    int unsigned     h;
    int unsigned     ax;
    int unsigned     ay;
    int unsigned     q;
    int unsigned     ang;
    int unsigned     span;
    int unsigned     b0;
    int unsigned     b1;
    longint unsigned mag;
    longint unsigned pos;
    longint unsigned part0;
    longint unsigned part1;
    longint unsigned acc;
    bin_result_t     r;
    nb = clamp_range(bins_reg, 1, MaxBins);
    w  = clamp_range(width_reg, 1, MaxWidth);
    h  = clamp_range(height_reg, 1, MaxHeight);
    ax = gx < 0 ? -int'(gx) : int'(gx);
    ay = gy < 0 ? -int'(gy) : int'(gy);
    if (row_cnt >= h) row_cnt = 0;
    if (col_cnt >= w) advance_row(h);

    mag = root_floor((longint'(ax) * ax + longint'(ay) * ay) << 16);
    q = first_quadrant_angle(ax, ay);
    if (gx >= 0 && gy >= 0) ang = q;
    else if (gx < 0 && gy >= 0) ang = 180 * 256 - q;
    else if (gx < 0) ang = 180 * 256 + q;
    else ang = 360 * 256 - q;
    if (ang >= 360 * 256) ang -= 360 * 256;
    span = full_reg ? 360 * 256 : 180 * 256;
    if (ang >= span) ang -= span;

    pos = (longint'(ang) * nb * 256) / span;
    b0 = int'(pos >> 8);
    if (b0 >= nb) b0 = nb - 1;
    b1 = (b0 + 1) % nb;
    part1 = (mag * (pos & 8'hFF)) >> 8;
    part0 = mag - part1;
    acc = longint'(row_sum[b0]) + part0;
    row_sum[b0] = SumW'(acc > SumMax ? SumMax : acc);
    acc = longint'(row_sum[b1]) + part1;
    row_sum[b1] = SumW'(acc > SumMax ? SumMax : acc);

    for (int unsigned n = 0; n < nb; n++) begin
      acc = (row_cnt == 0 ? 0 : longint'(prev_row[col_cnt * MaxBins + n])) + row_sum[n];
      r.sat = acc > ValMax;
      if (r.sat) acc = ValMax;
      prev_row[col_cnt * MaxBins + n] = acc[ValW-1:0];
      r.bin   = n[BinW-1:0];
      r.value = acc[ValW-1:0];
      r.last  = n == nb - 1;
      expected_bins.insert(expected_bins.size(), r);
    end

    col_cnt++;
    if (col_cnt >= w) advance_row(h);
  endtask

  // watch configuration, input and output transactions
  always @(posedge clk_i or negedge rst_ni) begin
    bin_result_t want;
    if (!rst_ni) begin
      expected_bins.delete();
      for (int n = 0; n < MaxBins; n++) row_sum[n] = '0;
      col_cnt = 0;
      row_cnt = 0;
      bins_reg = 5'd8;
      full_reg = 1'b0;
      width_reg = 11'd640;
      height_reg = 11'd480;
      fail_count_o = 0;
      result_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegNumBins: bins_reg = cfg_data_i[4:0];
          RegFullOri: full_reg = cfg_data_i[0];
          RegWidth:   width_reg = cfg_data_i[10:0];
          RegHeight:  height_reg = cfg_data_i[10:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_pixel(grad_x_i, grad_y_i);
      if (out_valid_i && !out_stall_i) begin
        result_count_o++;
        if (expected_bins.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected result: bin %0d value %0h last %0b sat %0b",
                     bin_index_i, integral_value_i, last_bin_i, saturated_i);
        end else begin
          want = expected_bins.pop_front();
          if (want.bin !== bin_index_i || want.value !== integral_value_i ||
              want.last !== last_bin_i || want.sat !== saturated_i) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: expected bin %0d value %0h last %0b sat %0b, got bin %0d value %0h last %0b sat %0b",
                       want.bin, want.value, want.last, want.sat,
                       bin_index_i, integral_value_i, last_bin_i, saturated_i);
          end
        end
      end
    end
  end

endmodule

// File: tb/sv/integral_orientation_histogram_test.sv
// testbench top for the integral orientation histogram: stimulus, idling and verdict
`timescale 1ns / 1ps
module integral_orientation_histogram_test;
  import ioh_pkg::*;

  localparam int CycleLimit = 1500000;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [GradW-1:0] grad_x;
  logic signed [GradW-1:0] grad_y;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [BinW-1:0]         bin_index;
  logic [ValW-1:0]         integral_value;
  logic                    last_bin;
  logic                    saturated;
  logic                    cfg_we;
  logic [1:0]              cfg_index;
  logic [CfgW-1:0]         cfg_data;
  int                      pending;
  int                      fail_count;
  int                      result_count;
  int                      send_idle_pct;
  int                      recv_idle_pct;
  int                      cycle_cnt = 0;
  int                      pixel_cnt;

  integral_orientation_histogram i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .grad_x_i         (grad_x),
    .grad_y_i         (grad_y),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .bin_index_o      (bin_index),
    .integral_value_o (integral_value),
    .last_bin_o       (last_bin),
    .saturated_o      (saturated),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  integral_orientation_histogram_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .grad_x_i         (grad_x),
    .grad_y_i         (grad_y),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .bin_index_i      (bin_index),
    .integral_value_i (integral_value),
    .last_bin_i       (last_bin),
    .saturated_i      (saturated),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .pending_o        (pending),
    .fail_count_o     (fail_count),
    .result_count_o   (result_count)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // receiver stalls at random
  always @(posedge clk_i) begin
    out_stall <= $urandom_range(99) < recv_idle_pct;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // one pixel transaction, with an optional gap before it
  task automatic send_pixel(input logic signed [GradW-1:0] gx, input logic signed [GradW-1:0] gy);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    grad_x   <= gx;
    grad_y   <= gy;
    do @(posedge clk_i); while (in_stall);
    pixel_cnt++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_setup(input int nb, input int fo, input int w, input int h);
    int vals[4];
    vals = '{nb, fo, w, h};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data  <= vals[i][CfgW-1:0];
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
  endtask

  // random gradient pairs: some from the field extremes, some small, the rest over the full field
  task automatic send_random(input int count);
    logic signed [GradW-1:0] pick[6];
    logic signed [GradW-1:0] gx;
    logic signed [GradW-1:0] gy;
    pick = '{11'sd0, 11'sd1, -11'sd1, 11'sd1023, -11'sd1024, 11'sd512};
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(3))
        0: begin
          gx = pick[$urandom_range(5)];
          gy = pick[$urandom_range(5)];
        end
        1: begin
          gx = GradW'(int'($urandom_range(16)) - 8);
          gy = GradW'(int'($urandom_range(16)) - 8);
        end
        default: begin
          gx = GradW'($urandom);
          gy = GradW'($urandom);
        end
      endcase
      send_pixel(gx, gy);
    end
  endtask

  // one-pixel image that brings the counters back to the image start
  task automatic rewind_image(input int nb, input int fo);
    write_setup(nb, fo, 1, 1);
    send_pixel(GradW'($urandom), GradW'($urandom));
    drain_results();
  endtask

  // one setting, then a rewind to the image start
  task automatic run_phase(input int nb, input int fo, input int w, input int h, input int count);
    write_setup(nb, fo, w, h);
    send_random(count);
    drain_results();
    rewind_image(nb, fo);
  endtask

  initial begin
    logic signed [GradW-1:0] corner_x[20];
    logic signed [GradW-1:0] corner_y[20];
    corner_x = '{0, 1023, -1024, 0, 0, 1023, -1024, 1023, -1024, 1, -1, -1, 1, 5, -5, 0,
                 1, -1024, 300, -2};
    corner_y = '{0, 0, 0, 1023, -1024, 1023, -1024, -1024, 1023, 1, 1, -1, -1, 0, 0, -5,
                 -1024, 1, -700, 3};
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    grad_x        = '0;
    grad_y        = '0;
    cfg_we        = 1'b0;
    cfg_index     = RegNumBins;
    cfg_data      = '0;
    pixel_cnt     = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // axes, diagonals and extremes at the reset setting
    for (int k = 0; k < 20; k++) send_pixel(corner_x[k], corner_y[k]);
    drain_results();
    rewind_image(8, 0);

    send_idle_pct = 16;
    recv_idle_pct = 70;
    run_phase(16, 1, 5, 3, 50);
    run_phase(1, 0, 1024, 2, 40);
    send_idle_pct = 70;
    recv_idle_pct = 16;
    // out-of-range values are clamped by the block
    run_phase(0, 1, 0, 2047, 40);
    run_phase(31, 0, 3, 4, 50);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(4, 1, 7, 1, 40);
    run_phase(2, 0, 2047, 1024, 40);

    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("covered %0d pixels and %0d bin results over 7 settings,", pixel_cnt, result_count);
    $display("both orientation ranges, 1 to 16 bins and clamped register values");
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
